// ===== hdl/lgg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgg_pkg
// shared types and constants of the life grid generation engine
// ----------------------------------------------------------------------------
package lgg_pkg;

   localparam int GRID_WIDTH_DEF  = 64;
   localparam int GRID_HEIGHT_DEF = 64;

   localparam int OPCODE_W = 3;
   localparam int INDEX_W  = 6;
   localparam int COUNT_W  = 4;

   // life rule: survive on two or three, birth on three
   localparam logic [COUNT_W-1:0] SURVIVE_LO = 4'd2;
   localparam logic [COUNT_W-1:0] BIRTH_CNT  = 4'd3;

   typedef enum logic [OPCODE_W-1:0] {
      OP_READ    = 3'd0,
      OP_WRITE   = 3'd1,
      OP_TOGGLE  = 3'd2,
      OP_CLEAR   = 3'd3,
      OP_ADVANCE = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_RESULT
   } state_type;

   // per-cycle control from the sequencer to the row update unit
   typedef struct packed {
      opcode_type         op;
      logic [INDEX_W-1:0] col;
      logic               write_bit;
      logic               hit;     // addressed row is at the tail
      logic               first;   // top row of the grid at the tail
      logic               last;    // bottom row of the grid at the tail
   } sweep_ctrl_type;

endpackage : lgg_pkg
`default_nettype wire

// ===== hdl/lgg_row_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgg_row_cell
// one grid row in the rotating row chain
// ----------------------------------------------------------------------------
module lgg_row_cell #(
   parameter int GRID_WIDTH = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  shift_en,
   input  wire logic [GRID_WIDTH-1:0] row_in,
   output logic      [GRID_WIDTH-1:0] row_out
);

   logic [GRID_WIDTH-1:0] row_ff;

   // all cells dead after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else if (shift_en) begin
         row_ff <= row_in;
      end
   end

   assign row_out = row_ff;

endmodule : lgg_row_cell
`default_nettype wire

// ===== hdl/lgg_row_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgg_row_update
// rewrites the row leaving the chain tail: edit, clear or next generation
// ----------------------------------------------------------------------------
module lgg_row_update #(
   parameter int GRID_WIDTH = 64
) (
   input  wire logic                   clock,
   input  wire logic                   shift_en,
   input  wire lgg_pkg::sweep_ctrl_type ctrl,
   input  wire logic [GRID_WIDTH-1:0]  tail_row,   // old row t
   input  wire logic [GRID_WIDTH-1:0]  next_row,   // old row t+1
   output logic      [GRID_WIDTH-1:0]  new_row
);
   import lgg_pkg::*;

   localparam int PW = GRID_WIDTH + 2;

   logic [GRID_WIDTH-1:0] prev_ff;   // old row t-1, snapshot of the previous tail
   logic [PW-1:0]         pad_prev;
   logic [PW-1:0]         pad_cur;
   logic [PW-1:0]         pad_next;
   logic [COUNT_W-1:0]    cnt;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         prev_ff <= tail_row;
      end
   end

   // rows padded with a dead cell on each side
   assign pad_prev = ctrl.first ? '0 : {1'b0, prev_ff, 1'b0};
   assign pad_cur  = {1'b0, tail_row, 1'b0};
   assign pad_next = ctrl.last ? '0 : {1'b0, next_row, 1'b0};

   always_comb begin
      new_row = tail_row;
      cnt     = '0;
      unique case (ctrl.op)
         OP_ADVANCE: begin
            for (int c = 0; c < GRID_WIDTH; c++) begin
               cnt = COUNT_W'($countones({pad_prev[c], pad_prev[c+1], pad_prev[c+2],
                                          pad_cur[c], pad_cur[c+2],
                                          pad_next[c], pad_next[c+1], pad_next[c+2]}));
               new_row[c] = (cnt == BIRTH_CNT) || (pad_cur[c+1] && (cnt == SURVIVE_LO));
            end
         end
         OP_CLEAR: begin
            new_row = '0;
         end
         OP_WRITE: begin
            for (int c = 0; c < GRID_WIDTH; c++) begin
               if (ctrl.hit && (int'(ctrl.col) == c)) begin
                  new_row[c] = ctrl.write_bit;
               end
            end
         end
         OP_TOGGLE: begin
            for (int c = 0; c < GRID_WIDTH; c++) begin
               if (ctrl.hit && (int'(ctrl.col) == c)) begin
                  new_row[c] = ~tail_row[c];
               end
            end
         end
         default: begin
            new_row = tail_row;
         end
      endcase
   end

endmodule : lgg_row_update
`default_nettype wire

// ===== hdl/life_grid_generation_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// life_grid_generation_engine
// game of life grid (b3/s23, dead edges) with cell access and generation step
// ----------------------------------------------------------------------------
// usage:
//  - req_ channel carries one operation word: read, write or toggle a cell,
//    clear the grid, or advance one generation; codes 5..7 act as a read
//  - rsp_ channel returns one word per request: the addressed cell and its
//    live-neighbour count after the operation
//  - the grid lives in a ring of GRID_HEIGHT row registers; every operation
//    rotates the ring once, one row per cycle, through the row update unit
//    at the tail, and one request is worked on at a time
//  - req_ready is high only in the idle state, not during a sweep or a result; a
//    finished word waits in the rsp_ register, and the next request may sweep
//    meanwhile; it then holds in its result state until the rsp_ register is free
//  - reset (synchronous) clears every cell and drops rsp_valid
// ----------------------------------------------------------------------------
module life_grid_generation_engine #(
   parameter int GRID_WIDTH  = lgg_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = lgg_pkg::GRID_HEIGHT_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [lgg_pkg::OPCODE_W-1:0] req_opcode,
   input  wire logic [lgg_pkg::INDEX_W-1:0]  req_col_index,
   input  wire logic [lgg_pkg::INDEX_W-1:0]  req_row_index,
   input  wire logic                         req_write_bit,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_cell_alive,
   output logic      [lgg_pkg::COUNT_W-1:0]  rsp_neighbour_count
);
   import lgg_pkg::*;

   localparam int RW  = $clog2(GRID_HEIGHT);        // sweep counter width
   localparam int XR  = $clog2(GRID_HEIGHT + 66);   // row compare width
   localparam int PW  = GRID_WIDTH + 2;             // padded row width
   localparam int PIW = $clog2(PW);
   localparam int XW  = $clog2(GRID_WIDTH + 66);    // column compare width

   // control
   state_type             state_ff, state_in;
   logic [RW-1:0]         sweep_cnt_ff, sweep_cnt_in;
   logic                  shift_en;
   logic                  load_rsp;
   logic                  req_take;
   logic                  last_row;

   // latched request word
   logic [OPCODE_W-1:0]   op_ff;
   logic [INDEX_W-1:0]    col_ff;
   logic [INDEX_W-1:0]    row_ff;
   logic                  wbit_ff;

   // rows around the addressed cell, captured as they are rewritten
   logic [GRID_WIDTH-1:0] up_ff, mid_ff, dn_ff;

   // result register
   logic                  rsp_valid_ff;
   logic                  alive_ff;
   logic [COUNT_W-1:0]    count_ff;

   // row chain
   logic [GRID_WIDTH-1:0] chain_q [GRID_HEIGHT];
   logic [GRID_WIDTH-1:0] new_row;
   sweep_ctrl_type        ctrl;

   logic [XR-1:0]         t_x, r_x;
   logic                  hit_up, hit_mid, hit_dn;

   // probe of the captured window
   logic [PW-1:0]         pad_up, pad_mid, pad_dn;
   logic [XW-1:0]         pos0, pos1, pos2;
   logic                  ok0, ok1, ok2;
   logic [7:0]            around;
   logic                  alive_now;
   logic [COUNT_W-1:0]    count_now;

   assign req_take = req_valid && req_ready;
   assign last_row = (sweep_cnt_ff == RW'(GRID_HEIGHT - 1));

   // ---------------------------------------------------------------- fsm
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SWEEP;
         ST_SWEEP:  if (last_row)  state_in = ST_RESULT;
         ST_RESULT: if (load_rsp)  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      shift_en  = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SWEEP:  shift_en  = 1'b1;
         ST_RESULT: load_rsp  = !rsp_valid_ff || rsp_ready;
         default:   req_ready = 1'b0;
      endcase
   end

   always_comb begin
      sweep_cnt_in = sweep_cnt_ff;
      if (shift_en) begin
         sweep_cnt_in = last_row ? '0 : sweep_cnt_ff + RW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sweep_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
      end
   end

   // latch the request word
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff   <= req_opcode;
         col_ff  <= req_col_index;
         row_ff  <= req_row_index;
         wbit_ff <= req_write_bit;
      end
   end

   // ---------------------------------------------------------------- row ring
   // tail (last cell) holds row t during sweep step t; the cell before it
   // holds row t+1; the update unit feeds the rewritten row into cell 0
   for (genvar i = 0; i < GRID_HEIGHT; i++) begin : g_chain
      if (i == 0) begin : g_head
         lgg_row_cell #(.GRID_WIDTH(GRID_WIDTH)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift_en(shift_en),
            .row_in  (new_row),
            .row_out (chain_q[i])
         );
      end else begin : g_body
         lgg_row_cell #(.GRID_WIDTH(GRID_WIDTH)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift_en(shift_en),
            .row_in  (chain_q[i-1]),
            .row_out (chain_q[i])
         );
      end
   end

   assign t_x     = XR'(sweep_cnt_ff);
   assign r_x     = XR'(row_ff);
   assign hit_mid = (t_x == r_x);
   assign hit_up  = (r_x != '0) && (t_x == r_x - XR'(1));
   assign hit_dn  = (t_x == r_x + XR'(1));

   assign ctrl.op        = opcode_type'(op_ff);
   assign ctrl.col       = col_ff;
   assign ctrl.write_bit = wbit_ff;
   assign ctrl.hit       = hit_mid;
   assign ctrl.first     = (sweep_cnt_ff == '0);
   assign ctrl.last      = last_row;

   lgg_row_update #(.GRID_WIDTH(GRID_WIDTH)) u_update (
      .clock   (clock),
      .shift_en(shift_en),
      .ctrl    (ctrl),
      .tail_row(chain_q[GRID_HEIGHT-1]),
      .next_row(chain_q[GRID_HEIGHT-2]),
      .new_row (new_row)
   );

   // rows outside the grid stay dead in the window
   always_ff @(posedge clock) begin
      if (req_take) begin
         up_ff  <= '0;
         mid_ff <= '0;
         dn_ff  <= '0;
      end else if (shift_en) begin
         if (hit_up)  up_ff  <= new_row;
         if (hit_mid) mid_ff <= new_row;
         if (hit_dn)  dn_ff  <= new_row;
      end
   end

   // ---------------------------------------------------------------- probe
   // padded position p stands for column p-1
   assign pad_up  = {1'b0, up_ff, 1'b0};
   assign pad_mid = {1'b0, mid_ff, 1'b0};
   assign pad_dn  = {1'b0, dn_ff, 1'b0};
   assign pos0    = XW'(col_ff);
   assign pos1    = pos0 + XW'(1);
   assign pos2    = pos0 + XW'(2);
   assign ok0     = (pos0 < XW'(PW));
   assign ok1     = (pos1 < XW'(PW));
   assign ok2     = (pos2 < XW'(PW));

   always_comb begin
      around = '0;
      if (ok0) begin
         around[0] = pad_up[pos0[PIW-1:0]];
         around[1] = pad_mid[pos0[PIW-1:0]];
         around[2] = pad_dn[pos0[PIW-1:0]];
      end
      if (ok1) begin
         around[3] = pad_up[pos1[PIW-1:0]];
         around[4] = pad_dn[pos1[PIW-1:0]];
      end
      if (ok2) begin
         around[5] = pad_up[pos2[PIW-1:0]];
         around[6] = pad_mid[pos2[PIW-1:0]];
         around[7] = pad_dn[pos2[PIW-1:0]];
      end
   end

   assign alive_now = ok1 ? pad_mid[pos1[PIW-1:0]] : 1'b0;
   assign count_now = COUNT_W'($countones(around));

   // ---------------------------------------------------------------- result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         alive_ff <= alive_now;
         count_ff <= count_now;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cell_alive      = alive_ff;
   assign rsp_neighbour_count = count_ff;

`ifndef SYNTH
   // a word appears only out of the result state
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("result word appeared outside the result state");

   // the sweep counter is parked at zero between requests
   a_cnt_parked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (sweep_cnt_ff == '0))
      else $error("sweep counter not at zero while idle");

   // a sweep always ends in the result state after its last row
   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) && last_row |=> (state_ff == ST_RESULT))
      else $error("sweep did not end in the result state");

   // never more than eight neighbours
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (count_ff <= COUNT_W'(8)))
      else $error("neighbour count above eight");
`endif

endmodule : life_grid_generation_engine
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the life grid generation engine
// ----------------------------------------------------------------------------
// keeps its own copy of the 64 x 64 cell grid and predicts every rsp word
// (cell value and live-neighbour count after the operation). a short directed
// run covers the empty grid, a full neighbourhood, unused codes and a blinker
// on the corner. random runs follow: seed patterns in small windows (often
// against an edge), then step them for several generations with reads and
// toggles mixed in. the runs use several idling profiles, and one run holds
// rsp_ready low long enough that the engine backs up and stalls req_ready.
// ----------------------------------------------------------------------------
module tb_top;
   import lgg_pkg::*;

   localparam int GRID_W = GRID_WIDTH_DEF;
   localparam int GRID_H = GRID_HEIGHT_DEF;

   // codes 5..7 are not operations; the engine answers them as a read
   localparam logic [OPCODE_W-1:0] OP_SPARE_5 = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

   localparam int HOLD_CYCLES   = 1000;          // long rsp_ready hold-off
   localparam int SETTLE_CYCLES = GRID_H + 16;   // one sweep plus margin
   localparam int RUN_LIMIT_NS  = 3_000_000;

   typedef struct packed {
      logic               alive;
      logic [COUNT_W-1:0] count;
   } life_answer_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   // engine ports; the inputs are all known from time zero
   logic                  req_valid     = 1'b0;
   logic                  req_ready;
   logic [OPCODE_W-1:0]   req_opcode    = '0;
   logic [INDEX_W-1:0]    req_col_index = '0;
   logic [INDEX_W-1:0]    req_row_index = '0;
   logic                  req_write_bit = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready     = 1'b0;
   logic                  rsp_cell_alive;
   logic [COUNT_W-1:0]    rsp_neighbour_count;

   life_grid_generation_engine DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_col_index       (req_col_index),
      .req_row_index       (req_row_index),
      .req_write_bit       (req_write_bit),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cell_alive      (rsp_cell_alive),
      .rsp_neighbour_count (rsp_neighbour_count)
   );

   // predicted grid and the answers still owed by the engine
   bit [GRID_W-1:0]  life_grid [GRID_H];
   life_answer_type  cell_answer_q [$];

   // idling knobs, percent per decision
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;

   // long hold-off request and its state
   logic hold_req = 1'b0;
   logic rsp_hold = 1'b0;

   // bookkeeping
   int err_count      = 0;
   int words_checked  = 0;
   int op_seen [8];
   int peak_count     = 0;
   int backup_cycles  = 0;

   // ------------------------------------------------------------------------
   // grid predictor
   // ------------------------------------------------------------------------

   // live cells around column c, given the rows above, at and below it
   function automatic logic [COUNT_W-1:0] count_in_rows(bit [GRID_W-1:0] up,
                                                        bit [GRID_W-1:0] mid,
                                                        bit [GRID_W-1:0] dn,
                                                        int c);
      logic [COUNT_W-1:0] n;
      int dc;
      n = '0;
      for (dc = -1; dc <= 1; dc++) begin
         if (c + dc >= 0 && c + dc < GRID_W) begin
            n += COUNT_W'(up[c+dc]) + COUNT_W'(dn[c+dc]);
            if (dc != 0)
               n += COUNT_W'(mid[c+dc]);
         end
      end
      return n;
   endfunction

   function automatic logic [COUNT_W-1:0] live_neighbours(int r, int c);
      bit [GRID_W-1:0] up, dn;
      up = (r > 0)          ? life_grid[r-1] : '0;
      dn = (r < GRID_H - 1) ? life_grid[r+1] : '0;
      return count_in_rows(up, life_grid[r], dn, c);
   endfunction

   // one b3/s23 generation from a snapshot, dead beyond the edges
   function automatic void step_generation();
      bit [GRID_W-1:0]    snap [GRID_H];
      bit [GRID_W-1:0]    up, dn;
      logic [COUNT_W-1:0] n;
      int r, c;
      for (r = 0; r < GRID_H; r++)
         snap[r] = life_grid[r];
      for (r = 0; r < GRID_H; r++) begin
         up = (r > 0)          ? snap[r-1] : '0;
         dn = (r < GRID_H - 1) ? snap[r+1] : '0;
         for (c = 0; c < GRID_W; c++) begin
            n = count_in_rows(up, snap[r], dn, c);
            if (snap[r][c])
               life_grid[r][c] = (n == SURVIVE_LO || n == BIRTH_CNT);
            else
               life_grid[r][c] = (n == BIRTH_CNT);
         end
      end
   endfunction

   // apply one operation to the predicted grid and return the answer
   function automatic life_answer_type predict_cell_answer(logic [OPCODE_W-1:0] op,
                                                           logic [INDEX_W-1:0]  row,
                                                           logic [INDEX_W-1:0]  col,
                                                           logic                wbit);
      life_answer_type ans;
      int r;
      case (op)
         OP_WRITE:   life_grid[row][col] = wbit;
         OP_TOGGLE:  life_grid[row][col] = ~life_grid[row][col];
         OP_CLEAR: begin
            for (r = 0; r < GRID_H; r++)
               life_grid[r] = '0;
         end
         OP_ADVANCE: step_generation();
         default: ;  // read and spare codes leave the grid alone
      endcase
      ans.alive = life_grid[row][col];
      ans.count = live_neighbours(row, col);
      return ans;
   endfunction

   // ------------------------------------------------------------------------
   // req side: one word per call, valid kept high between back-to-back words
   // ------------------------------------------------------------------------
   task automatic send_word(input logic [OPCODE_W-1:0] op, input int row,
                            input int col, input logic wbit);
      int gap;
      life_answer_type ans;
      if (req_idle_pct > 0 && $urandom_range(0, 99) < req_idle_pct) begin
         // gap length spread over a whole sweep so it lands on every phase
         gap = $urandom_range(1, GRID_H + 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_row_index <= row[INDEX_W-1:0];
      req_col_index <= col[INDEX_W-1:0];
      req_write_bit <= wbit;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      // accepted at this edge
      ans = predict_cell_answer(op, row[INDEX_W-1:0], col[INDEX_W-1:0], wbit);
      cell_answer_q.push_back(ans);
      op_seen[op]++;
   endtask

   // random word anywhere, any code
   task automatic send_noise_word();
      send_word(OPCODE_W'($urandom_range(0, 7)), $urandom_range(0, GRID_H - 1),
                $urandom_range(0, GRID_W - 1), 1'($urandom_range(0, 1)));
   endtask

   // ------------------------------------------------------------------------
   // rsp side: ready pattern, long hold-off timer, checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || rsp_hold)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // hold-off counted here, independent of the sender
   initial begin : rsp_hold_timer
      wait (hold_req);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin : rsp_check
      life_answer_type want;
      if (!reset && rsp_hold && req_valid && !req_ready)
         backup_cycles++;
      if (!reset && rsp_valid && rsp_ready) begin
         words_checked++;
         if (cell_answer_q.size() == 0) begin
            $error("rsp word with no answer pending: cell_alive %0d neighbour_count %0d",
                   rsp_cell_alive, rsp_neighbour_count);
            err_count++;
         end else begin
            want = cell_answer_q.pop_front();
            if (rsp_cell_alive !== want.alive) begin
               $error("cell_alive: expected %0d, actual %0d", want.alive, rsp_cell_alive);
               err_count++;
            end
            if (rsp_neighbour_count !== want.count) begin
               $error("neighbour_count: expected %0d, actual %0d",
                      want.count, rsp_neighbour_count);
               err_count++;
            end
            if (want.count > peak_count)
               peak_count = want.count;
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // grid comes out of reset empty
   task automatic test_reset_grid();
      send_word(OP_READ, 0, 0, 1'b0);
      send_word(OP_READ, GRID_H - 1, GRID_W - 1, 1'b1);
   endtask

   // fill all eight neighbours of one cell, then read, toggle, write, step
   task automatic test_full_neighbourhood();
      int dr, dc;
      for (dr = -1; dr <= 1; dr++)
         for (dc = -1; dc <= 1; dc++)
            if (dr != 0 || dc != 0)
               send_word(OP_WRITE, 5 + dr, 5 + dc, 1'b1);
      send_word(OP_READ, 5, 5, 1'b0);
      send_word(OP_TOGGLE, 5, 5, 1'b0);
      send_word(OP_WRITE, 4, 4, 1'b0);
      send_word(OP_ADVANCE, 5, 5, 1'b0);
   endtask

   // unused codes answer as a read and change nothing
   task automatic test_spare_codes();
      send_word(OP_SPARE_5, GRID_H - 1, 0, 1'b1);
      send_word(OP_SPARE_6, 0, GRID_W - 1, 1'b1);
      send_word(OP_SPARE_7, 5, 6, 1'b1);
   endtask

   // blinker on the bottom-right corner: the part past the edge stays dead
   task automatic test_corner_blinker();
      send_word(OP_CLEAR, GRID_H - 1, GRID_W - 1, 1'b0);
      send_word(OP_WRITE, GRID_H - 1, GRID_W - 3, 1'b1);
      send_word(OP_TOGGLE, GRID_H - 1, GRID_W - 2, 1'b0);
      send_word(OP_WRITE, GRID_H - 1, GRID_W - 1, 1'b1);
      send_word(OP_ADVANCE, GRID_H - 2, GRID_W - 2, 1'b0);
      send_word(OP_ADVANCE, GRID_H - 1, GRID_W - 2, 1'b0);
   endtask

   // seed a small window (often against an edge), then run it for a few
   // generations with reads and toggles in between; some noise mixed in
   task automatic test_random_life(input int n_words, input int idle_pct,
                                   input int stall_pct);
      int done, h, w, r0, c0, k, gens;
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      done = 0;
      while (done < n_words) begin
         if ($urandom_range(0, 3) == 0) begin
            send_word(OP_CLEAR, $urandom_range(0, GRID_H - 1),
                      $urandom_range(0, GRID_W - 1), 1'($urandom_range(0, 1)));
            done++;
         end
         h = $urandom_range(3, 10);
         w = $urandom_range(3, 10);
         case ($urandom_range(0, 3))
            0:       r0 = 0;
            1:       r0 = GRID_H - h;
            default: r0 = $urandom_range(0, GRID_H - h);
         endcase
         case ($urandom_range(0, 3))
            0:       c0 = 0;
            1:       c0 = GRID_W - w;
            default: c0 = $urandom_range(0, GRID_W - w);
         endcase
         // seeding
         for (k = 0; k < h * w / 2 && done < n_words; k++) begin
            if ($urandom_range(0, 9) == 0)
               send_noise_word();
            else if ($urandom_range(0, 3) == 0)
               send_word(OP_TOGGLE, r0 + $urandom_range(0, h - 1),
                         c0 + $urandom_range(0, w - 1), 1'($urandom_range(0, 1)));
            else
               send_word(OP_WRITE, r0 + $urandom_range(0, h - 1),
                         c0 + $urandom_range(0, w - 1), ($urandom_range(0, 9) < 7));
            done++;
         end
         // evolution; addresses may step one past the window
         gens = $urandom_range(1, 8);
         for (k = 0; k < gens * 3 && done < n_words; k++) begin
            if (k % 3 == 0)
               send_word(OP_ADVANCE, r0 - 1 + $urandom_range(0, h + 1),
                         c0 - 1 + $urandom_range(0, w + 1), 1'($urandom_range(0, 1)));
            else if ($urandom_range(0, 9) == 0)
               send_noise_word();
            else if ($urandom_range(0, 4) == 0)
               send_word(OP_TOGGLE, r0 - 1 + $urandom_range(0, h + 1),
                         c0 - 1 + $urandom_range(0, w + 1), 1'($urandom_range(0, 1)));
            else
               send_word(OP_READ, r0 - 1 + $urandom_range(0, h + 1),
                         c0 - 1 + $urandom_range(0, w + 1), 1'($urandom_range(0, 1)));
            done++;
         end
      end
   endtask

   // rsp_ready held off far longer than a sweep while words keep coming:
   // one answer parks in the rsp register, the next sweep finishes and waits,
   // and req_ready has to drop
   task automatic test_output_backpressure();
      int k;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_req <= 1'b1;
      for (k = 0; k < 8; k++)
         send_word(OP_ADVANCE, $urandom_range(0, GRID_H - 1),
                   $urandom_range(0, GRID_W - 1), 1'($urandom_range(0, 1)));
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin : main_seq
      int r;
      for (r = 0; r < GRID_H; r++)
         life_grid[r] = '0;
      foreach (op_seen[i])
         op_seen[i] = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_grid();
      test_full_neighbourhood();
      test_spare_codes();
      test_corner_blinker();

      test_random_life(480, 0, 0);     // no idling
      test_random_life(480, 67, 0);    // sender idles
      test_output_backpressure();
      test_random_life(480, 0, 67);    // receiver stalls
      test_random_life(480, 10, 10);   // both, lightly

      req_valid <= 1'b0;
      while (cell_answer_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d words: read %0d, write %0d, toggle %0d, clear %0d, advance %0d, spare %0d",
               words_checked, op_seen[OP_READ], op_seen[OP_WRITE], op_seen[OP_TOGGLE],
               op_seen[OP_CLEAR], op_seen[OP_ADVANCE],
               op_seen[OP_SPARE_5] + op_seen[OP_SPARE_6] + op_seen[OP_SPARE_7]);
      $display("peak neighbour count %0d, %0d req stall cycles while rsp_ready was held off",
               peak_count, backup_cycles);
      if (err_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // run limit, well above the slowest legal run
   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
